// ===== hdl/tfan_pkg.sv =====
// Package for the three-band fan thermostat.
// Holds the register map, band codes, reset values and the result beat type.
// No dependencies.
`timescale 1ns / 1ps

package tfan_pkg;

  // Configuration register indexes, in address order (byte address 4*index).
  typedef enum logic [2:0] {
    REG_LOW_LIMIT       = 3'd0,
    REG_HIGH_LIMIT      = 3'd1,
    REG_TOLERANCE       = 3'd2,
    REG_STORED_SETPOINT = 3'd3,
    REG_COLD_COMPARE    = 3'd4,
    REG_NORMAL_COMPARE  = 3'd5,
    REG_HOT_COMPARE     = 3'd6,
    REG_UNUSED          = 3'd7
  } reg_index_t;

  // Band codes; BAND_NONE marks that no pass has run yet.
  typedef enum logic [1:0] {
    BAND_COLD   = 2'd0,
    BAND_NORMAL = 2'd1,
    BAND_HOT    = 2'd2,
    BAND_NONE   = 2'd3
  } band_t;

  localparam int unsigned ADDR_W = 5;

  localparam logic [7:0] LOW_LIMIT_RESET       = 8'd25;
  localparam logic [7:0] HIGH_LIMIT_RESET      = 8'd50;
  localparam logic [7:0] TOLERANCE_RESET       = 8'd1;
  localparam logic [7:0] STORED_SETPOINT_RESET = 8'd30;
  localparam logic [8:0] COLD_COMPARE_RESET    = 9'd255;
  localparam logic [8:0] NORMAL_COMPARE_RESET  = 9'd127;
  localparam logic [8:0] HOT_COMPARE_RESET     = 9'd0;

  // Setpoint used when the stored value lies outside the limits.
  localparam logic [7:0] FALLBACK_SETPOINT = 8'd30;
  // Top of the PWM counter; compare values saturate here.
  localparam logic [8:0] PWM_TOP = 9'd320;
  localparam logic [7:0] TEMP_MAX = 8'd255;

  // One result beat.
  typedef struct packed {
    band_t      band;
    logic [8:0] compare_value;
    logic       updated;
    logic [7:0] setpoint_now;
    logic [7:0] temperature_now;
  } result_t;

endpackage

// ===== hdl/three_band_fan_thermostat.sv =====
// Top level of the three-band fan thermostat.
// Uses tfan_pkg for the register map, band codes and result beat type.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one control pass per beat:
//   the minus and plus button levels and a 10-bit sensor sample. Output
//   channel (out_valid / out_stall) returns exactly one result beat per
//   input beat: band, compare value, band-change flag, setpoint and
//   temperature.
//   Results are registered. Throughput is one beat per cycle while in_stall
//   is low, set by the single compute stage that updates setpoint, button
//   arming and last band.
//   A two-entry output (result register plus skid register) lets a new beat
//   be taken while a result waits; in_stall rises only when both are full,
//   so one beat can still be taken after the receiver starts stalling.
//   Configuration goes through the APB port at byte address 4*index; write
//   it only while the block is idle.
//   Reset (rst, synchronous) restores all configuration registers to their
//   defaults, clears the arming state and makes the next pass reload the
//   setpoint from stored_setpoint (or the fallback) and report updated = 1.
module three_band_fan_thermostat
  import tfan_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              minus_level,
  input  logic              plus_level,
  input  logic [9:0]        sensor_sample,
  // Output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        band,
  output logic [8:0]        compare_value,
  output logic              updated,
  output logic [7:0]        setpoint_now,
  output logic [7:0]        temperature_now
);

  // Configuration registers.
  logic [7:0] low_limit;
  logic [7:0] high_limit;
  logic [7:0] tolerance;
  logic [7:0] stored_setpoint;
  logic [8:0] cold_compare;
  logic [8:0] normal_compare;
  logic [8:0] hot_compare;

  // Control state.
  logic [7:0] setpoint;
  logic       minus_armed;
  logic       plus_armed;
  band_t      last_band;
  logic       started;

  // Output register and skid register.
  result_t    out_beat;
  result_t    skid_beat;
  logic       skid_valid;

  logic       cfg_write;
  reg_index_t cfg_index;
  logic       accept;
  result_t    result_next;
  logic [7:0] setpoint_next;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);
  assign in_stall  = skid_valid;
  assign accept    = in_valid & ~in_stall;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit       <= LOW_LIMIT_RESET;
      high_limit      <= HIGH_LIMIT_RESET;
      tolerance       <= TOLERANCE_RESET;
      stored_setpoint <= STORED_SETPOINT_RESET;
      cold_compare    <= COLD_COMPARE_RESET;
      normal_compare  <= NORMAL_COMPARE_RESET;
      hot_compare     <= HOT_COMPARE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOW_LIMIT:       low_limit       <= pwdata[7:0];
        REG_HIGH_LIMIT:      high_limit      <= pwdata[7:0];
        REG_TOLERANCE:       tolerance       <= pwdata[7:0];
        REG_STORED_SETPOINT: stored_setpoint <= pwdata[7:0];
        REG_COLD_COMPARE:    cold_compare    <= pwdata[8:0];
        REG_NORMAL_COMPARE:  normal_compare  <= pwdata[8:0];
        REG_HOT_COMPARE:     hot_compare     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_index)
      REG_LOW_LIMIT:       prdata = {24'd0, low_limit};
      REG_HIGH_LIMIT:      prdata = {24'd0, high_limit};
      REG_TOLERANCE:       prdata = {24'd0, tolerance};
      REG_STORED_SETPOINT: prdata = {24'd0, stored_setpoint};
      REG_COLD_COMPARE:    prdata = {23'd0, cold_compare};
      REG_NORMAL_COMPARE:  prdata = {23'd0, normal_compare};
      REG_HOT_COMPARE:     prdata = {23'd0, hot_compare};
      default:             prdata = 32'd0;
    endcase
  end

  // One control pass: setpoint load and button steps, temperature, band.
  always_comb begin
    logic [7:0]        sp_start;
    logic [7:0]        sp_minus;
    logic [7:0]        temp;
    logic signed [9:0] diff;
    logic signed [9:0] tol_s;
    logic [8:0]        cmp;

    // The first pass loads the stored setpoint, or the fallback if it is
    // outside the limits.
    if (started) begin
      sp_start = setpoint;
    end else if (stored_setpoint >= low_limit && stored_setpoint <= high_limit) begin
      sp_start = stored_setpoint;
    end else begin
      sp_start = FALLBACK_SETPOINT;
    end

    // A release of an armed button steps the setpoint, minus first.
    if (!minus_level && minus_armed && sp_start > low_limit) begin
      sp_minus = sp_start - 8'd1;
    end else begin
      sp_minus = sp_start;
    end
    if (!plus_level && plus_armed && sp_minus < high_limit) begin
      setpoint_next = sp_minus + 8'd1;
    end else begin
      setpoint_next = sp_minus;
    end

    // Halve the sample and saturate.
    temp = sensor_sample[9] ? TEMP_MAX : sensor_sample[8:1];

    // Signed band decision against setpoint plus or minus tolerance.
    diff  = signed'({2'b00, temp}) - signed'({2'b00, setpoint_next});
    tol_s = signed'({2'b00, tolerance});
    if (diff > tol_s) begin
      result_next.band = BAND_HOT;
      cmp              = hot_compare;
    end else if (-diff > tol_s) begin
      result_next.band = BAND_COLD;
      cmp              = cold_compare;
    end else begin
      result_next.band = BAND_NORMAL;
      cmp              = normal_compare;
    end

    result_next.compare_value   = (cmp > PWM_TOP) ? PWM_TOP : cmp;
    result_next.updated         = (result_next.band != last_band);
    result_next.setpoint_now    = setpoint_next;
    result_next.temperature_now = temp;
  end

  // Control state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= 8'd0;
      minus_armed <= 1'b0;
      plus_armed  <= 1'b0;
      last_band   <= BAND_NONE;
      started     <= 1'b0;
    end else if (accept) begin
      setpoint    <= setpoint_next;
      minus_armed <= minus_level;
      plus_armed  <= plus_level;
      last_band   <= result_next.band;
      started     <= 1'b1;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept) begin
        skid_beat <= result_next;
      end
    end else if (skid_valid) begin
      out_beat <= skid_beat;
    end else if (accept) begin
      out_beat <= result_next;
    end
  end

  assign band            = out_beat.band;
  assign compare_value   = out_beat.compare_value;
  assign updated         = out_beat.updated;
  assign setpoint_now    = out_beat.setpoint_now;
  assign temperature_now = out_beat.temperature_now;

`ifndef SYNTHESIS
  // The skid entry only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without output valid");

  // A shown result always carries a real band.
  a_band_real: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_beat.band != BAND_NONE)
    else $error("result band is the none code");

  // Compare values never exceed the PWM top.
  a_cmp_clipped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> compare_value <= PWM_TOP)
    else $error("compare value above PWM top");

  // An accepted beat with a free output shows up the next cycle.
  a_latency_one: assert property (@(posedge clk) disable iff (rst)
    accept && !(out_valid && out_stall) |=> out_valid && !skid_valid)
    else $error("accepted beat did not reach output");

  // After any accepted beat the setpoint is loaded.
  a_started: assert property (@(posedge clk) disable iff (rst)
    accept |=> started && last_band != BAND_NONE)
    else $error("pass did not mark the block started");
`endif

endmodule

// ===== verif/tb_three_band_fan_thermostat.sv =====
// Self-checking testbench for the three-band fan thermostat.
// Drives control passes and APB writes, predicts each result beat in SV and compares.
// Depends on tfan_pkg and three_band_fan_thermostat.
`timescale 1ns / 1ps

module tb_three_band_fan_thermostat;
  import tfan_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BEATS = 112;

  bit clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic minus_level;
  logic plus_level;
  logic [9:0] sensor_sample;
  logic out_valid;
  logic out_stall;
  logic [1:0] band;
  logic [8:0] compare_value;
  logic updated;
  logic [7:0] setpoint_now;
  logic [7:0] temperature_now;

  // Shadow copy of the register file, indexed by register.
  logic [8:0] cfg_shadow [0:6];

  // Shadow of the control state.
  logic [7:0] sp_cur = '0;
  logic sp_loaded = 1'b0;
  logic arm_minus = 1'b0;
  logic arm_plus = 1'b0;
  band_t prev_band = BAND_NONE;

  result_t pending_results [$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  three_band_fan_thermostat dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .minus_level(minus_level),
    .plus_level(plus_level),
    .sensor_sample(sensor_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .band(band),
    .compare_value(compare_value),
    .updated(updated),
    .setpoint_now(setpoint_now),
    .temperature_now(temperature_now)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Works out one control pass: button handling, temperature and band choice.
  function automatic result_t predict_pass(input logic m, input logic p, input logic [9:0] s);
    result_t r;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] tol;
    logic [7:0] stored;
    logic [8:0] cmp;
    logic [7:0] t;
    int diff;
    lo = cfg_shadow[REG_LOW_LIMIT][7:0];
    hi = cfg_shadow[REG_HIGH_LIMIT][7:0];
    tol = cfg_shadow[REG_TOLERANCE][7:0];
    stored = cfg_shadow[REG_STORED_SETPOINT][7:0];
    // The first pass loads the stored setpoint, or the fallback if out of limits.
    if (!sp_loaded) begin
      sp_loaded = 1'b1;
      sp_cur = (stored >= lo && stored <= hi) ? stored : FALLBACK_SETPOINT;
    end
    // A button steps the setpoint on release; minus goes first.
    if (m) begin
      arm_minus = 1'b1;
    end else if (arm_minus) begin
      arm_minus = 1'b0;
      if (sp_cur > lo) sp_cur = sp_cur - 8'd1;
    end
    if (p) begin
      arm_plus = 1'b1;
    end else if (arm_plus) begin
      arm_plus = 1'b0;
      if (sp_cur < hi) sp_cur = sp_cur + 8'd1;
    end
    // Halve the sample and saturate.
    t = s[9] ? TEMP_MAX : s[8:1];
    diff = int'(t) - int'(sp_cur);
    if (diff > int'(tol)) begin
      r.band = BAND_HOT;
      cmp = cfg_shadow[REG_HOT_COMPARE];
    end else if (-diff > int'(tol)) begin
      r.band = BAND_COLD;
      cmp = cfg_shadow[REG_COLD_COMPARE];
    end else begin
      r.band = BAND_NORMAL;
      cmp = cfg_shadow[REG_NORMAL_COMPARE];
    end
    r.compare_value = (cmp > PWM_TOP) ? PWM_TOP : cmp;
    r.updated = (r.band != prev_band);
    r.setpoint_now = sp_cur;
    r.temperature_now = t;
    prev_band = r.band;
    return r;
  endfunction

  // Sample that reads back as the given temperature, clamped to the legal range.
  function automatic logic [9:0] sample_at(input int t);
    if (t <= 0) begin
      return 10'($urandom_range(1));
    end else if (t >= 255) begin
      return 10'($urandom_range(510, 1023));
    end
    return {t[8:0], 1'($urandom_range(1))};
  endfunction

  // Compares each accepted result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no prediction pending");
      end else begin
        want = pending_results.pop_front();
        if (band !== want.band)
          report_mismatch($sformatf("band got %0d want %0d", band, want.band));
        if (compare_value !== want.compare_value)
          report_mismatch($sformatf("compare_value got %0d want %0d",
                                    compare_value, want.compare_value));
        if (updated !== want.updated)
          report_mismatch($sformatf("updated got %0d want %0d", updated, want.updated));
        if (setpoint_now !== want.setpoint_now)
          report_mismatch($sformatf("setpoint_now got %0d want %0d",
                                    setpoint_now, want.setpoint_now));
        if (temperature_now !== want.temperature_now)
          report_mismatch($sformatf("temperature_now got %0d want %0d",
                                    temperature_now, want.temperature_now));
      end
    end
  end

  // Sends one control pass; starts and ends at a falling edge.
  task automatic send_pass(input logic m, input logic p, input logic [9:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    minus_level <= m;
    plus_level <= p;
    sensor_sample <= s;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_pass(m, p, s));
    @(negedge clk);
  endtask

  // Lets the block run dry so that registers may be changed.
  task automatic settle_block;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_read_check(input reg_index_t idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== {23'd0, cfg_shadow[idx]})
      report_mismatch($sformatf("register %s read %0d want %0d",
                                idx.name(), got, cfg_shadow[idx]));
  endtask

  // Writes one register, updates the shadow and reads it back.
  task automatic reg_write(input reg_index_t idx, input int unsigned val);
    logic [8:0] masked;
    masked = (idx >= REG_COLD_COMPARE) ? 9'(val) : {1'b0, 8'(val)};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {23'd0, masked};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_shadow[idx] = masked;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    reg_read_check(idx);
  endtask

  task automatic apply_settings(input int unsigned lo, input int unsigned hi,
                                input int unsigned tol, input int unsigned stored,
                                input int unsigned cold, input int unsigned normal,
                                input int unsigned hot);
    reg_write(REG_LOW_LIMIT, lo);
    reg_write(REG_HIGH_LIMIT, hi);
    reg_write(REG_TOLERANCE, tol);
    reg_write(REG_STORED_SETPOINT, stored);
    reg_write(REG_COLD_COMPARE, cold);
    reg_write(REG_NORMAL_COMPARE, normal);
    reg_write(REG_HOT_COMPARE, hot);
  endtask

  // Every register reads its reset value.
  task automatic test_reset_values;
    cfg_shadow[REG_LOW_LIMIT] = {1'b0, LOW_LIMIT_RESET};
    cfg_shadow[REG_HIGH_LIMIT] = {1'b0, HIGH_LIMIT_RESET};
    cfg_shadow[REG_TOLERANCE] = {1'b0, TOLERANCE_RESET};
    cfg_shadow[REG_STORED_SETPOINT] = {1'b0, STORED_SETPOINT_RESET};
    cfg_shadow[REG_COLD_COMPARE] = COLD_COMPARE_RESET;
    cfg_shadow[REG_NORMAL_COMPARE] = NORMAL_COMPARE_RESET;
    cfg_shadow[REG_HOT_COMPARE] = HOT_COMPARE_RESET;
    for (int i = 0; i <= int'(REG_HOT_COMPARE); i++) begin
      reg_read_check(reg_index_t'(i));
    end
  endtask

  // The first pass loads the setpoint; the path taken is picked at random,
  // since reset comes only once.
  task automatic test_first_pass;
    case ($urandom_range(2))
      0: reg_write(REG_STORED_SETPOINT, 40);
      1: reg_write(REG_STORED_SETPOINT, 10);
      default: begin
        // Stored value out of range and the fallback outside the limits too.
        reg_write(REG_LOW_LIMIT, 60);
        reg_write(REG_HIGH_LIMIT, 90);
        reg_write(REG_STORED_SETPOINT, 200);
      end
    endcase
    send_pass(1'b0, 1'b0, 10'($urandom_range(1023)));
    settle_block;
  endtask

  // Press and release sequences on both buttons.
  task automatic test_button_steps;
    apply_settings(25, 50, 1, 35, COLD_COMPARE_RESET, NORMAL_COMPARE_RESET,
                   HOT_COMPARE_RESET);
    send_pass(1'b1, 1'b0, sample_at(sp_cur));
    send_pass(1'b0, 1'b0, sample_at(sp_cur - 1));
    send_pass(1'b0, 1'b1, sample_at(sp_cur + 2));
    send_pass(1'b0, 1'b1, sample_at(sp_cur - 2));
    send_pass(1'b0, 1'b0, sample_at(sp_cur));
    // Both released together: minus is handled before plus.
    send_pass(1'b1, 1'b1, sample_at(sp_cur + 1));
    send_pass(1'b0, 1'b0, sample_at(sp_cur));
    settle_block;
  endtask

  // Steps blocked at the limits, then crossed limits.
  task automatic test_limit_edges;
    reg_write(REG_LOW_LIMIT, sp_cur);
    reg_write(REG_HIGH_LIMIT, sp_cur);
    send_pass(1'b1, 1'b1, sample_at(sp_cur));
    send_pass(1'b0, 1'b0, sample_at(sp_cur));
    settle_block;
    reg_write(REG_LOW_LIMIT, sp_cur - 5);
    reg_write(REG_HIGH_LIMIT, sp_cur - 10);
    send_pass(1'b1, 1'b1, sample_at(sp_cur));
    send_pass(1'b0, 1'b0, sample_at(sp_cur));
    settle_block;
  endtask

  // Sample extremes and the saturation point of the temperature.
  task automatic test_temperature_extremes;
    send_pass(1'b0, 1'b0, 10'd0);
    send_pass(1'b0, 1'b0, 10'd1);
    send_pass(1'b0, 1'b0, 10'd510);
    send_pass(1'b0, 1'b0, 10'd511);
    send_pass(1'b0, 1'b0, 10'd512);
    send_pass(1'b0, 1'b0, 10'd1023);
    settle_block;
  endtask

  // Band boundaries at zero, small and full tolerance.
  task automatic test_band_edges;
    reg_write(REG_TOLERANCE, 0);
    send_pass(1'b0, 1'b0, sample_at(sp_cur + 1));
    send_pass(1'b0, 1'b0, sample_at(sp_cur - 1));
    settle_block;
    reg_write(REG_TOLERANCE, 3);
    send_pass(1'b0, 1'b0, sample_at(sp_cur + 3));
    send_pass(1'b0, 1'b0, sample_at(sp_cur + 4));
    send_pass(1'b0, 1'b0, sample_at(sp_cur - 4));
    settle_block;
    reg_write(REG_TOLERANCE, 255);
    send_pass(1'b0, 1'b0, 10'd1023);
    settle_block;
  endtask

  // Compare values above the PWM top, and a register change inside one band.
  task automatic test_compare_values;
    reg_write(REG_TOLERANCE, 2);
    reg_write(REG_COLD_COMPARE, 511);
    reg_write(REG_NORMAL_COMPARE, 321);
    reg_write(REG_HOT_COMPARE, PWM_TOP);
    send_pass(1'b0, 1'b0, sample_at(sp_cur - 10));
    send_pass(1'b0, 1'b0, sample_at(sp_cur));
    settle_block;
    reg_write(REG_NORMAL_COMPARE, 0);
    send_pass(1'b0, 1'b0, sample_at(sp_cur + 1));
    send_pass(1'b0, 1'b0, sample_at(sp_cur + 10));
    settle_block;
  endtask

  // Phases of random button sequences and samples under varied settings and idling.
  task automatic test_random_traffic;
    logic hold_m;
    logic hold_p;
    logic m;
    logic p;
    logic [9:0] s;
    int span;
    int unsigned lo;
    hold_m = 1'b0;
    hold_p = 1'b0;
    for (int phase = 0; phase < 8; phase++) begin
      settle_block;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      case (phase)
        0: apply_settings(LOW_LIMIT_RESET, HIGH_LIMIT_RESET, TOLERANCE_RESET,
                          STORED_SETPOINT_RESET, COLD_COMPARE_RESET,
                          NORMAL_COMPARE_RESET, HOT_COMPARE_RESET);
        2: apply_settings(0, 255, 0, $urandom_range(255), 0, PWM_TOP, 511);
        3: apply_settings($urandom_range(128, 255), $urandom_range(0, 127),
                          $urandom_range(10), $urandom_range(255),
                          $urandom_range(511), $urandom_range(511), $urandom_range(511));
        4: apply_settings(255, 255, 255, 255, 511, 511, 511);
        default: begin
          // Limits a modest window around the current setpoint most of the time.
          lo = (sp_cur > 20) ? sp_cur - $urandom_range(20) : 0;
          apply_settings(lo, lo + $urandom_range(40), $urandom_range(8),
                         $urandom_range(255), $urandom_range(511),
                         $urandom_range(511), $urandom_range(511));
        end
      endcase
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if ($urandom_range(99) < 30) hold_m = ~hold_m;
        if ($urandom_range(99) < 30) hold_p = ~hold_p;
        if ($urandom_range(99) < 8) begin
          m = 1'($urandom_range(1));
          p = 1'($urandom_range(1));
        end else begin
          m = hold_m;
          p = hold_p;
        end
        span = int'(cfg_shadow[REG_TOLERANCE][7:0]) + 3;
        if ($urandom_range(3) == 0 || span > 40) begin
          s = 10'($urandom_range(1023));
        end else begin
          s = sample_at(int'(sp_cur) + int'($urandom_range(2 * span)) - span);
        end
        send_pass(m, p, s);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    settle_block;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    minus_level <= 1'b0;
    plus_level <= 1'b0;
    sensor_sample <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values;
    test_first_pass;
    test_button_steps;
    test_limit_edges;
    test_temperature_extremes;
    test_band_edges;
    test_compare_values;
    test_random_traffic;

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
